FILE: design/unique_id_bitmap_allocator_defines.svh
// Assertion helpers for the ID allocator.
`ifndef UNIQUE_ID_BITMAP_ALLOCATOR_DEFINES_SVH
`define UNIQUE_ID_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define UBMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define UBMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ubma_pkg.sv
package ubma_pkg;

    localparam int unsigned ID_W         = 28;
    localparam logic [ID_W:0] ID_SPAN    = 29'h1000_0000;
    localparam logic [ID_W-1:0] BASE_MIN = 28'h000_0001;
    localparam int unsigned DEF_POOL_IDS = 4096;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic            func;
        logic [ID_W-1:0] number;
    } t_req;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] alloc_number;
        logic            number_valid;
    } t_rsp;

    // log2 of the bitmap word width: 64-bit words, 8-bit for tiny pools
    function automatic int unsigned word_lg(input int unsigned pool);
        return (pool >= 64) ? 6 : 3;
    endfunction

    function automatic int unsigned word_count(input int unsigned pool);
        return (pool + (1 << word_lg(pool)) - 1) >> word_lg(pool);
    endfunction

    function automatic int unsigned addr_bits(input int unsigned n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

FILE: design/ubma_ram.sv
module ubma_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/ubma_scan.sv
module ubma_scan #(
    parameter int unsigned POOL_IDS = 4096
) (
    input  logic [(1 << ubma_pkg::word_lg(POOL_IDS))-1:0]                  i_data,
    input  logic [ubma_pkg::addr_bits(ubma_pkg::word_count(POOL_IDS))-1:0] i_word,
    input  logic [$clog2(ubma_pkg::word_count(POOL_IDS) + 2)-1:0]          i_step,
    input  logic [ubma_pkg::word_lg(POOL_IDS)-1:0]                         i_start_bit,
    input  logic [$clog2(POOL_IDS + 1)-1:0]                                i_usable,
    output logic                                                           o_hit,
    output logic [ubma_pkg::word_lg(POOL_IDS)-1:0]                         o_bit,
    output logic [(1 << ubma_pkg::word_lg(POOL_IDS))-1:0]                  o_set_data
);
    import ubma_pkg::*;

    localparam int unsigned LG     = word_lg(POOL_IDS);
    localparam int unsigned W      = 1 << LG;
    localparam int unsigned NW     = word_count(POOL_IDS);
    localparam int unsigned WA_W   = addr_bits(NW);
    localparam int unsigned STEP_W = $clog2(NW + 2);
    localparam int unsigned CNT_W  = $clog2(POOL_IDS + 1);
    localparam int unsigned SLOT_W = WA_W + LG;
    localparam int unsigned CW     = ((CNT_W > SLOT_W) ? CNT_W : SLOT_W) + 1;

    logic [CW-1:0] usable_ext;
    logic [CW-1:0] base_ext;
    logic [W-1:0]  umask;
    logic [W-1:0]  pmask;
    logic [W-1:0]  cand;

    // umask: slot inside the usable pool; pmask: first pass takes bits at or
    // above the start bit, the wrap pass over the same word the bits below
    always_comb begin
        usable_ext = CW'(i_usable);
        base_ext   = CW'({i_word, {LG{1'b0}}});
        for (int b = 0; b < W; b++) begin
            umask[b] = (base_ext + CW'(b)) < usable_ext;
            if (i_step == '0) begin
                pmask[b] = LG'(b) >= i_start_bit;
            end else if (i_step == STEP_W'(NW)) begin
                pmask[b] = LG'(b) < i_start_bit;
            end else begin
                pmask[b] = 1'b1;
            end
        end
        cand = ~i_data & umask & pmask;
    end

    always_comb begin
        o_bit = '0;
        for (int b = W - 1; b >= 0; b--) begin
            if (cand[b]) begin
                o_bit = LG'(b);
            end
        end
    end

    assign o_hit      = |cand;
    assign o_set_data = i_data | (cand & (~cand + W'(1)));

endmodule

FILE: design/unique_id_bitmap_allocator.sv
// Channel   | Direction | Handshake            | Payload
// request   | in        | start & !busy        | i_req  (func, number)
// result    | out       | o_done, one cycle    | o_rsp  (status, alloc_number, number_valid)
// config    | in        | i_cfg_valid & ready  | i_cfg_data (reserved_base)
//
// Bitmap held in NW = ceil(POOL_IDS/W) words of W = 64 bits (8 below 64 ids; 4096 ids: 64 words), one
// read port; the scan reads one word per cycle, pipelined against the evaluate.
// Allocate: S_SCAN reads from the word of the last allocated id; a hit goes on to S_WRITE, full ends the scan.
// Free: S_CHECK reads the word, S_FREE_WR clears the bit; out of range ends in S_CHECK. Result strobe follows.
// After reset a clearing pass zeroes the bitmap word by word with busy high.
// Results cannot be held off; o_cfg_ready is always high.
module unique_id_bitmap_allocator #(
    parameter int unsigned POOL_IDS = ubma_pkg::DEF_POOL_IDS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  ubma_pkg::t_req             i_req,
    output logic                       o_done,
    output ubma_pkg::t_rsp             o_rsp,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [ubma_pkg::ID_W-1:0]  i_cfg_data
);
    import ubma_pkg::*;

    localparam int unsigned LG     = word_lg(POOL_IDS);
    localparam int unsigned W      = 1 << LG;
    localparam int unsigned NW     = word_count(POOL_IDS);
    localparam int unsigned WA_W   = addr_bits(NW);
    localparam int unsigned STEP_W = $clog2(NW + 2);
    localparam int unsigned CNT_W  = $clog2(POOL_IDS + 1);
    localparam int unsigned SLOT_W = WA_W + LG;

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_WRITE   = 3'd3;
    localparam logic [2:0] S_CHECK   = 3'd4;
    localparam logic [2:0] S_FREE_WR = 3'd5;

    logic [2:0]        r_state;
    logic [ID_W-1:0]   r_base;
    logic [CNT_W-1:0]  r_usable;
    logic [CNT_W-1:0]  n_usable;
    logic [SLOT_W-1:0] r_search;
    logic [ID_W-1:0]   r_number;
    logic              r_nvalid;
    logic [WA_W-1:0]   r_rd_word;
    logic [STEP_W-1:0] r_rd_step;
    logic              r_ev_vld;
    logic [WA_W-1:0]   r_ev_word;
    logic [STEP_W-1:0] r_ev_step;
    logic [WA_W-1:0]   r_hit_word;
    logic [LG-1:0]     r_hit_bit;
    logic [W-1:0]      r_wdata;
    logic [WA_W-1:0]   r_clr_word;
    logic              r_done;
    t_rsp              r_rsp;

    logic [ID_W:0]     room;
    logic [ID_W-1:0]   off;
    logic              in_range;
    logic              accept;
    logic              rd_issue;
    logic              mem_we;
    logic [WA_W-1:0]   mem_waddr;
    logic [W-1:0]      mem_wdata;
    logic              mem_re;
    logic [WA_W-1:0]   mem_raddr;
    logic [W-1:0]      mem_rdata;
    logic              hit;
    logic [LG-1:0]     hit_bit;
    logic [W-1:0]      set_data;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_rsp       = r_rsp;

    // usable slots = min(POOL_IDS, 2^28 - base); the user must move base only while idle, the block does not enforce it
    assign room     = ID_SPAN - {1'b0, r_base};
    assign n_usable = (room < (ID_W + 1)'(POOL_IDS)) ? CNT_W'(room) : CNT_W'(POOL_IDS);

    assign off      = r_number - r_base;
    assign in_range = r_nvalid && (off < ID_W'(r_usable));

    // one word read per scan step: first word, the others, first word again
    assign rd_issue = (r_state == S_SCAN) && (r_rd_step <= STEP_W'(NW));

    // one request at a time and the write lands before the next read, so no
    // two accesses to a word overlap
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_hit_word;
        mem_wdata = r_wdata;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_word;
                mem_wdata = '0;
            end
            S_WRITE: begin
                mem_we = 1'b1;
            end
            S_FREE_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata & ~(W'(1) << r_hit_bit);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign mem_re    = rd_issue || ((r_state == S_CHECK) && in_range);
    assign mem_raddr = (r_state == S_CHECK) ? off[SLOT_W-1:LG] : r_rd_word;

    ubma_ram #(
        .DEPTH (NW),
        .WIDTH (W),
        .AW    (WA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ubma_scan #(
        .POOL_IDS (POOL_IDS)
    ) u_scan (
        .i_data      (mem_rdata),
        .i_word      (r_ev_word),
        .i_step      (r_ev_step),
        .i_start_bit (r_search[LG-1:0]),
        .i_usable    (r_usable),
        .o_hit       (hit),
        .o_bit       (hit_bit),
        .o_set_data  (set_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_word <= '0;
            r_base     <= BASE_MIN;
            r_usable   <= CNT_W'(POOL_IDS);
            r_search   <= '0;
            r_ev_vld   <= 1'b0;
            r_rd_step  <= '0;
            r_done     <= 1'b0;
        end else begin
            r_usable <= n_usable;
            r_done   <= 1'b0;
            if (i_cfg_valid) begin
                r_base <= (i_cfg_data == '0) ? BASE_MIN : i_cfg_data;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_word <= r_clr_word + WA_W'(1);
                    if (r_clr_word == WA_W'(NW - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_number  <= i_req.number;
                        r_nvalid  <= (i_req.number >= r_base);
                        r_rd_word <= r_search[SLOT_W-1:LG];
                        r_rd_step <= '0;
                        r_ev_vld  <= 1'b0;
                        r_state   <= (i_req.func == FUNC_ALLOC) ? S_SCAN : S_CHECK;
                    end
                end
                S_SCAN: begin
                    if (rd_issue) begin
                        r_ev_vld  <= 1'b1;
                        r_ev_word <= r_rd_word;
                        r_ev_step <= r_rd_step;
                        r_rd_step <= r_rd_step + STEP_W'(1);
                        r_rd_word <= (r_rd_word == WA_W'(NW - 1)) ? '0
                                                                  : r_rd_word + WA_W'(1);
                    end else begin
                        r_ev_vld <= 1'b0;
                    end
                    if (r_ev_vld) begin
                        if (hit) begin
                            r_hit_word <= r_ev_word;
                            r_hit_bit  <= hit_bit;
                            r_wdata    <= set_data;
                            r_state    <= S_WRITE;
                        end else if (r_ev_step == STEP_W'(NW)) begin
                            r_done  <= 1'b1;
                            r_rsp   <= '{status: ST_FULL, alloc_number: '0,
                                         number_valid: r_nvalid};
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_WRITE: begin
                    r_search <= {r_hit_word, r_hit_bit};
                    r_done   <= 1'b1;
                    r_rsp    <= '{status: ST_DONE,
                                  alloc_number: r_base + ID_W'({r_hit_word, r_hit_bit}),
                                  number_valid: r_nvalid};
                    r_state  <= S_IDLE;
                end
                S_CHECK: begin
                    if (in_range) begin
                        r_hit_word <= off[SLOT_W-1:LG];
                        r_hit_bit  <= off[LG-1:0];
                        r_state    <= S_FREE_WR;
                    end else begin
                        r_done  <= 1'b1;
                        r_rsp   <= '{status: ST_RANGE, alloc_number: '0,
                                     number_valid: r_nvalid};
                        r_state <= S_IDLE;
                    end
                end
                S_FREE_WR: begin
                    r_done  <= 1'b1;
                    r_rsp   <= '{status: ST_DONE, alloc_number: '0,
                                 number_valid: r_nvalid};
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`include "unique_id_bitmap_allocator_defines.svh"

    `UBMA_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "request accepted but busy stayed low")
    `UBMA_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result strobe while still busy")
    `UBMA_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_done && (o_rsp.status != ST_DONE), o_rsp.alloc_number == '0, "failed request returned an id")
    `UBMA_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_done, (o_rsp.status == ST_DONE) || (o_rsp.status == ST_FULL) || (o_rsp.status == ST_RANGE), "illegal status code")

endmodule
